>>> src/rwr_pkg.sv
// Package for the reorder window receiver: constants, payload structs and codes.
package rwr_pkg;

  localparam int WINDOW = 32;
  localparam int FULL_FRAME_BYTES = 1000;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W = SLOT_W + 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic {
    OP_RECEIVE = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_FINAL   = 2'd1,
    KIND_MISSING = 2'd2,
    KIND_STATUS  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAST_FRAME  = 1'b0,
    CFG_TAIL_ABSENT = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RUN_SCAN,
    S_RUN_PLAN,
    S_RUN_READ,
    S_RUN_EMIT,
    S_RUN_DONE,
    S_TAIL_EMIT,
    S_FLAGS,
    S_STATUS,
    S_REQ_COUNT,
    S_REQ_EMIT
  } state_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] seq_num;
    logic        is_short;
    logic [9:0]  tail_bytes;
    logic [31:0] payload_handle;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_frame;
    logic [31:0] out_payload;
    logic [9:0]  out_tail_bytes;
    logic        last;
    logic        transfer_done;
    logic        all_received;
  } result_t;

endpackage

>>> src/reorder_window_receiver.sv
// Selective-repeat receive window that releases numbered frames in order.
// One item is taken at a time: item_stall is low only while the block is idle. A slot
// address unit (ring head plus slot offset) walks the window one slot per cycle while no
// result is stalled. A frame that is buffered, dropped or is the short final frame passes
// through dispatch and the flag update to a status result, or to the final frame's result.
// The expected frame releases the run of buffered frames behind it, and the final frame
// too when it follows: the run is found one slot per cycle, and each released frame passes
// through one payload memory read before its transfer. A missing-frame request counts and
// then lists the window one slot per cycle while no result is stalled. Every item yields at
// least one result, and a stalled result output holds the sequencer at that point.
module reorder_window_receiver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  rwr_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output rwr_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rwr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rwr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  rwr_pkg::state_t state, state_next;

  logic [15:0]                last_frame;
  logic                       tail_absent;
  logic [15:0]                expected;
  logic [rwr_pkg::SLOT_W-1:0] head;
  logic [rwr_pkg::WINDOW-1:0] present;
  logic [31:0]                payload_store [rwr_pkg::WINDOW];
  logic [31:0]                rdata;
  logic                       tail_present;
  logic                       tail_released;
  logic [31:0]                tail_payload;
  logic [9:0]                 tail_size;
  logic signed [7:0]          outstanding;

  rwr_pkg::item_t             cur;
  logic [rwr_pkg::CNT_W-1:0]  k;
  logic [rwr_pkg::CNT_W-1:0]  run;
  logic [rwr_pkg::CNT_W-1:0]  cnt;
  logic [rwr_pkg::CNT_W-1:0]  emitted;
  logic                       go;
  logic                       flag_done;
  logic                       flag_all;

  logic [15:0]                off_full;
  logic                       older;
  logic                       beyond;
  logic                       hit;
  logic                       in_win;
  logic                       buffer_ok;
  logic                       op_request;
  logic [rwr_pkg::SUM_W-1:0]  slot_operand;
  logic [rwr_pkg::SUM_W-1:0]  slot_sum;
  logic [rwr_pkg::SLOT_W-1:0] phys;
  logic                       present_at;
  logic [16:0]                scan_frame;
  logic                       scan_end;
  logic                       scan_full;
  logic                       tail_miss;
  logic [rwr_pkg::CNT_W-1:0]  total;
  logic [15:0]                total_ext;
  logic [15:0]                new_exp;
  logic                       run_tail_go;
  logic                       short_go;
  logic                       done_now;
  logic signed [7:0]          outstanding_dec;
  logic [9:0]                 bytes_sat;
  logic                       mem_we;
  logic                       emit_req;
  logic                       can_emit;
  logic                       fire;
  rwr_pkg::result_t           emit_item;

  assign cfg_ready = 1'b1;
  assign item_stall = (state != rwr_pkg::S_IDLE);
  assign op_request = (cur.operation == rwr_pkg::OP_REQUEST);

  assign older = (cur.seq_num < expected);
  assign beyond = (cur.seq_num >= last_frame);
  assign hit = !older && !beyond && (cur.seq_num == expected);
  assign off_full = cur.seq_num - expected;
  assign in_win = (off_full < 16'(rwr_pkg::WINDOW));
  assign buffer_ok = !older && !beyond && !hit && in_win;

  // Shared slot address unit: physical slot of window offset relative to the ring head.
  assign slot_operand = (state == rwr_pkg::S_DISPATCH) ?
                        rwr_pkg::SUM_W'(off_full[rwr_pkg::SLOT_W-1:0]) :
                        rwr_pkg::SUM_W'(k);
  assign slot_sum = rwr_pkg::SUM_W'(head) + slot_operand;
  assign phys = (slot_sum >= rwr_pkg::SUM_W'(rwr_pkg::WINDOW)) ?
                rwr_pkg::SLOT_W'(slot_sum - rwr_pkg::SUM_W'(rwr_pkg::WINDOW)) :
                rwr_pkg::SLOT_W'(slot_sum);
  assign present_at = present[phys];

  assign scan_frame = {1'b0, expected} + 17'(k);
  assign scan_end = (scan_frame >= {1'b0, last_frame});
  assign scan_full = (k == rwr_pkg::CNT_W'(rwr_pkg::WINDOW));
  assign tail_miss = (scan_frame == {1'b0, last_frame}) && !tail_absent && !tail_present;
  assign total = scan_full ? cnt : (cnt + rwr_pkg::CNT_W'(tail_miss));
  assign total_ext = 16'(total);

  assign new_exp = expected + 16'(run);
  assign run_tail_go = tail_present && !tail_released && (new_exp >= last_frame);
  assign short_go = !tail_absent && !tail_released && (expected >= last_frame);
  assign done_now = (expected >= last_frame) && (tail_released || tail_absent);
  assign outstanding_dec = (outstanding != -8'sd128) ? (outstanding - 8'sd1) : outstanding;
  assign bytes_sat = (16'(cur.tail_bytes) >= 16'(rwr_pkg::FULL_FRAME_BYTES)) ?
                     10'(rwr_pkg::FULL_FRAME_BYTES - 1) : cur.tail_bytes;

  assign mem_we = (state == rwr_pkg::S_DISPATCH) && !op_request && !cur.is_short &&
                  buffer_ok && !present_at;

  assign can_emit = !result_valid || !result_stall;
  assign fire = emit_req && can_emit;

  always_ff @(posedge clk) begin
    state <= rst ? rwr_pkg::S_IDLE : state_next;
  end

  always_comb begin
    state_next = state;
    emit_req = 1'b0;
    emit_item = '0;
    emit_item.transfer_done = flag_done;
    emit_item.all_received = flag_all;
    case (state)
      rwr_pkg::S_IDLE: begin
        if (item_valid) begin
          state_next = rwr_pkg::S_DISPATCH;
        end
      end
      rwr_pkg::S_DISPATCH: begin
        if (op_request) begin
          state_next = rwr_pkg::S_REQ_COUNT;
        end else if (!cur.is_short && hit) begin
          state_next = rwr_pkg::S_RUN_SCAN;
        end else begin
          state_next = rwr_pkg::S_FLAGS;
        end
      end
      rwr_pkg::S_RUN_SCAN: begin
        if (scan_full || !present_at) begin
          state_next = rwr_pkg::S_RUN_PLAN;
        end
      end
      rwr_pkg::S_RUN_PLAN: begin
        state_next = rwr_pkg::S_RUN_READ;
      end
      rwr_pkg::S_RUN_READ: begin
        state_next = rwr_pkg::S_RUN_EMIT;
      end
      rwr_pkg::S_RUN_EMIT: begin
        emit_req = 1'b1;
        emit_item.kind = rwr_pkg::KIND_FRAME;
        emit_item.out_frame = expected + 16'(k);
        emit_item.out_payload = (k == '0) ? cur.payload_handle : rdata;
        emit_item.last = (k == run - rwr_pkg::CNT_W'(1)) && !go;
        if (can_emit) begin
          state_next = (k == run - rwr_pkg::CNT_W'(1)) ? rwr_pkg::S_RUN_DONE :
                       rwr_pkg::S_RUN_READ;
        end
      end
      rwr_pkg::S_RUN_DONE: begin
        state_next = go ? rwr_pkg::S_TAIL_EMIT : rwr_pkg::S_IDLE;
      end
      rwr_pkg::S_TAIL_EMIT: begin
        emit_req = 1'b1;
        emit_item.kind = rwr_pkg::KIND_FINAL;
        emit_item.out_frame = last_frame;
        emit_item.out_payload = tail_payload;
        emit_item.out_tail_bytes = tail_size;
        emit_item.last = 1'b1;
        if (can_emit) begin
          state_next = rwr_pkg::S_IDLE;
        end
      end
      rwr_pkg::S_FLAGS: begin
        state_next = go ? rwr_pkg::S_TAIL_EMIT : rwr_pkg::S_STATUS;
      end
      rwr_pkg::S_STATUS: begin
        emit_req = 1'b1;
        emit_item.kind = rwr_pkg::KIND_STATUS;
        emit_item.last = 1'b1;
        if (can_emit) begin
          state_next = rwr_pkg::S_IDLE;
        end
      end
      rwr_pkg::S_REQ_COUNT: begin
        if (scan_full || scan_end) begin
          state_next = (total == '0) ? rwr_pkg::S_STATUS : rwr_pkg::S_REQ_EMIT;
        end
      end
      rwr_pkg::S_REQ_EMIT: begin
        emit_item.kind = rwr_pkg::KIND_MISSING;
        emit_item.out_frame = scan_frame[15:0];
        if (scan_end) begin
          emit_req = 1'b1;
          emit_item.last = 1'b1;
          if (can_emit) begin
            state_next = rwr_pkg::S_IDLE;
          end
        end else if (!present_at) begin
          emit_req = 1'b1;
          emit_item.last = (emitted == cnt - rwr_pkg::CNT_W'(1));
          if (can_emit && emit_item.last) begin
            state_next = rwr_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = rwr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_store[phys] <= cur.payload_handle;
    end
    if (state == rwr_pkg::S_RUN_READ) begin
      rdata <= payload_store[phys];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (fire) begin
      result <= emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame <= '0;
      tail_absent <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rwr_pkg::CFG_LAST_FRAME: last_frame <= cfg_data;
        rwr_pkg::CFG_TAIL_ABSENT: tail_absent <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == rwr_pkg::S_IDLE && item_valid) begin
      cur <= item;
    end
    if (rst) begin
      expected <= '0;
      head <= '0;
      present <= '0;
      tail_present <= 1'b0;
      tail_released <= 1'b0;
      tail_size <= '0;
      outstanding <= '0;
      go <= 1'b0;
      flag_done <= 1'b0;
      flag_all <= 1'b0;
      k <= '0;
      run <= '0;
      cnt <= '0;
      emitted <= '0;
    end else begin
      case (state)
        rwr_pkg::S_DISPATCH: begin
          go <= !op_request && cur.is_short && short_go;
          cnt <= '0;
          k <= op_request ? '0 : rwr_pkg::CNT_W'(1);
          if (!op_request) begin
            if (cur.is_short) begin
              if (!tail_absent) begin
                outstanding <= outstanding_dec;
                tail_released <= tail_released || short_go;
                if (!tail_present) begin
                  tail_present <= 1'b1;
                  tail_payload <= cur.payload_handle;
                  tail_size <= bytes_sat;
                end
              end
            end else if (hit) begin
              outstanding <= outstanding_dec;
            end else if (buffer_ok) begin
              outstanding <= outstanding_dec;
              present[phys] <= 1'b1;
            end
          end
        end
        rwr_pkg::S_RUN_SCAN: begin
          if (scan_full || !present_at) begin
            run <= k;
          end else begin
            k <= k + rwr_pkg::CNT_W'(1);
          end
        end
        rwr_pkg::S_RUN_PLAN: begin
          go <= run_tail_go;
          flag_done <= (new_exp >= last_frame) &&
                       (tail_released || run_tail_go || tail_absent);
          flag_all <= (outstanding <= 8'sd0);
          k <= '0;
        end
        rwr_pkg::S_RUN_EMIT: begin
          if (can_emit) begin
            present[phys] <= 1'b0;
            k <= k + rwr_pkg::CNT_W'(1);
          end
        end
        rwr_pkg::S_RUN_DONE: begin
          expected <= new_exp;
          head <= phys;
          tail_released <= tail_released || go;
        end
        rwr_pkg::S_FLAGS: begin
          flag_done <= done_now;
          flag_all <= (outstanding <= 8'sd0);
        end
        rwr_pkg::S_REQ_COUNT: begin
          if (scan_full || scan_end) begin
            cnt <= total;
            outstanding <= (total_ext > 16'd127) ? 8'sd127 : 8'(total_ext);
            flag_done <= done_now;
            flag_all <= (total == '0);
            k <= '0;
            emitted <= '0;
          end else begin
            cnt <= cnt + rwr_pkg::CNT_W'(!present_at);
            k <= k + rwr_pkg::CNT_W'(1);
          end
        end
        rwr_pkg::S_REQ_EMIT: begin
          if (!scan_end) begin
            if (present_at) begin
              k <= k + rwr_pkg::CNT_W'(1);
            end else if (can_emit) begin
              k <= k + rwr_pkg::CNT_W'(1);
              emitted <= emitted + rwr_pkg::CNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // The slot at the ring head is the expected frame and is never buffered.
  assert property (@(posedge clk) disable iff (rst) !present[head])
    else $error("expected-frame slot marked present");

  // Each buffered frame released after the expected one must be held in its slot.
  assert property (@(posedge clk) disable iff (rst)
    (state == rwr_pkg::S_RUN_EMIT) && (k != '0) |-> present_at)
    else $error("releasing a slot that holds no frame");

  // After the final result of an item only the window update may remain before idle.
  assert property (@(posedge clk) disable iff (rst)
    fire && emit_item.last |=>
      (state == rwr_pkg::S_IDLE) || (state == rwr_pkg::S_RUN_DONE))
    else $error("sequencer busy after the last result transfer");

  // A request reloads the outstanding count with a nonnegative value.
  assert property (@(posedge clk) disable iff (rst)
    (state == rwr_pkg::S_REQ_EMIT) |-> !outstanding[7])
    else $error("negative outstanding count after a request");

endmodule
